// ===== rtl/client_session_table_aging_top_defines.svh =====
// Assertion macros used by the session table checker.
`ifndef CLIENT_SESSION_TABLE_AGING_TOP_DEFINES_SVH
`define CLIENT_SESSION_TABLE_AGING_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define CSTA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define CSTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/csta_pkg.sv =====
// Types and constants of the client session table.
package csta_pkg;

	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int SLOT_W   = 6;
	localparam int TIME_W   = 32;
	localparam int OUTC_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [PORT_W-1:0] BASE_PORT_RST = 16'd32768;
	localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd60000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_PORT = 1'b0,
		REG_TIMEOUT   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_CONNECT   = 1'b0,
		OP_HEARTBEAT = 1'b1
	} op_t;

	typedef enum logic [OUTC_W-1:0] {
		OUT_MATCHED   = 3'd0,
		OUT_INSERTED  = 3'd1,
		OUT_REPLACED  = 3'd2,
		OUT_FULL      = 3'd3,
		OUT_HEARTBEAT = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN1,
		ST_SCAN2,
		ST_HEART,
		ST_DONE
	} state_t;

	// Write enables of the two slot memories.
	typedef struct packed {
		logic id;
		logic seen;
	} mem_we_t;

endpackage

// ===== rtl/csta_req_if.sv =====
// Request channel of the session table.
interface csta_req_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [csta_pkg::IP_W-1:0]      source_ip;
	logic [csta_pkg::PORT_W-1:0]    source_port;
	logic [csta_pkg::SLOT_W-1:0]    slot_in;
	logic [csta_pkg::TIME_W-1:0]    now_ms;

	modport source (output valid, op, source_ip, source_port, slot_in, now_ms, input ready);
	modport sink (input valid, op, source_ip, source_port, slot_in, now_ms, output ready);
endinterface

// ===== rtl/csta_rsp_if.sv =====
// Response channel of the session table.
interface csta_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [csta_pkg::SLOT_W-1:0]    slot_index;
	logic [csta_pkg::PORT_W-1:0]    assigned_port;
	logic [csta_pkg::OUTC_W-1:0]    outcome;

	modport source (output valid, slot_index, assigned_port, outcome, input ready);
	modport sink (input valid, slot_index, assigned_port, outcome, output ready);
endinterface

// ===== rtl/csta_slot_mem.sv =====
// Slot storage: client identity memory and keepalive memory, registered read.
module csta_slot_mem #(
	parameter int SLOTS = 63,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [IDX_W-1:0]              rd_addr,
	output logic [csta_pkg::IP_W-1:0]     rd_ip,
	output logic [csta_pkg::PORT_W-1:0]   rd_port,
	output logic [csta_pkg::TIME_W-1:0]   rd_seen,
	input  csta_pkg::mem_we_t             we,
	input  logic [IDX_W-1:0]              wr_addr,
	input  logic [csta_pkg::IP_W-1:0]     wr_ip,
	input  logic [csta_pkg::PORT_W-1:0]   wr_port,
	input  logic [csta_pkg::TIME_W-1:0]   wr_seen
);

	localparam int ID_W = csta_pkg::IP_W + csta_pkg::PORT_W;

	logic [ID_W-1:0]                id_mem   [SLOTS];
	logic [csta_pkg::TIME_W-1:0]    seen_mem [SLOTS];
	logic [ID_W-1:0]                id_s1;
	logic [csta_pkg::TIME_W-1:0]    seen_s1;

	always_ff @(posedge clk) begin
		if (we.id) begin
			id_mem[wr_addr] <= {wr_ip, wr_port};
		end
		if (rd_en) begin
			id_s1 <= id_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we.seen) begin
			seen_mem[wr_addr] <= wr_seen;
		end
		if (rd_en) begin
			seen_s1 <= seen_mem[rd_addr];
		end
	end

	assign rd_ip   = id_s1[ID_W-1:csta_pkg::PORT_W];
	assign rd_port = id_s1[csta_pkg::PORT_W-1:0];
	assign rd_seen = seen_s1;

endmodule

// ===== rtl/client_session_table_aging_top.sv =====
// Client session table with aging: slot allocation, reuse and keepalive refresh.
// A connect reads one slot per cycle, first in a scan for an empty or matching slot, then
// in a stale scan; the table works on one request at a time and takes the next only when
// the response register takes the result.
// Reset: arst_n clears control state, then a clearing pass over every slot empties the
// table before the first request is taken; configuration writes are taken at any time.
module client_session_table_aging_top #(
	parameter int SLOTS = 63
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [csta_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [csta_pkg::CFG_DATA_W-1:0]   cfg_data,
	csta_req_if.sink                          req,
	csta_rsp_if.source                        rsp
);

	// CNT_W holds a slot number 1..SLOTS (and a scan counter that runs up to SLOTS),
	// IDX_W addresses the memory, SW holds a slot number next to the 6-bit slot field.
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SW    = (CNT_W > csta_pkg::SLOT_W) ? CNT_W : csta_pkg::SLOT_W;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(SLOTS);
	localparam logic [SW-1:0]    SLOTS_SW = SW'(SLOTS);

	csta_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [csta_pkg::PORT_W-1:0] base_port_q;
	logic [csta_pkg::TIME_W-1:0] timeout_q;

	// The request being worked on.
	logic [csta_pkg::IP_W-1:0]     ip_q;
	logic [csta_pkg::PORT_W-1:0]   port_q;
	logic [csta_pkg::SLOT_W-1:0]   sel_q;
	logic [csta_pkg::TIME_W-1:0]   now_q;

	// Scan pipeline: rd_idx_q is the next slot to read, the _s1 stage holds the
	// slot whose data the memory shows in this cycle.
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_v_s1;
	logic [CNT_W-1:0] idx_s1;
	logic [CNT_W-1:0] clr_idx_q;

	// Finished result waiting to move into the response register.
	logic [SW-1:0]              res_slot_q;
	csta_pkg::outcome_t         res_outc_q;

	// Response register.
	logic                           out_v_q;
	logic [csta_pkg::SLOT_W-1:0]    out_slot_q;
	logic [csta_pkg::PORT_W-1:0]    out_port_q;
	csta_pkg::outcome_t             out_outc_q;

	logic [csta_pkg::IP_W-1:0]     rd_ip;
	logic [csta_pkg::PORT_W-1:0]   rd_port;
	logic [csta_pkg::TIME_W-1:0]   rd_seen;
	logic [csta_pkg::TIME_W-1:0]   age;

	logic accept;
	logic scanning;
	logic issue;
	logic hit1, hit2, hit;
	logic pass_end;
	logic stop;
	logic hb_ok;
	logic out_free;
	logic [SW-1:0] sel_m1;
	logic [SW-1:0] scan_slot;

	csta_pkg::mem_we_t          mem_we;
	logic [IDX_W-1:0]           wr_addr;
	logic [csta_pkg::IP_W-1:0]  wr_ip;
	logic [csta_pkg::PORT_W-1:0] wr_port;
	logic [csta_pkg::TIME_W-1:0] wr_seen;

	csta_slot_mem #(
		.SLOTS(SLOTS)
	) u_mem (
		.clk     (clk),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_ip   (rd_ip),
		.rd_port (rd_port),
		.rd_seen (rd_seen),
		.we      (mem_we),
		.wr_addr (wr_addr),
		.wr_ip   (wr_ip),
		.wr_port (wr_port),
		.wr_seen (wr_seen)
	);

	// Slot tests on the data read in this cycle. The first scan stops at the first
	// empty slot or at a slot that already belongs to this client, whichever comes
	// first; an empty slot wins when both hold. The second scan looks for the first
	// slot whose keepalive age, taken modulo 2^32, has reached the timeout.
	assign scanning  = (state_q == csta_pkg::ST_SCAN1) || (state_q == csta_pkg::ST_SCAN2);
	assign age       = now_q - rd_seen;
	assign hit1      = rd_v_s1 && (state_q == csta_pkg::ST_SCAN1) &&
		((rd_port == '0) || ((rd_ip == ip_q) && (rd_port == port_q)));
	assign hit2      = rd_v_s1 && (state_q == csta_pkg::ST_SCAN2) && (age >= timeout_q);
	assign hit       = hit1 || hit2;
	assign pass_end  = rd_v_s1 && (idx_s1 == LAST_IDX) && !hit;
	assign stop      = hit || pass_end;
	assign issue     = scanning && !stop && (rd_idx_q < SLOTS_C);
	assign scan_slot = SW'(idx_s1) + SW'(1);

	// A heartbeat names slots 1..SLOTS; anything else is turned away.
	assign hb_ok  = (sel_q != '0) && (SW'(sel_q) <= SLOTS_SW);
	assign sel_m1 = SW'(sel_q) - SW'(1);

	assign out_free = !out_v_q || rsp.ready;
	assign accept   = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csta_pkg::ST_CLEAR: begin
				if (clr_idx_q == LAST_IDX) begin
					state_d = csta_pkg::ST_IDLE;
				end
			end
			csta_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.op == csta_pkg::OP_HEARTBEAT) ?
						csta_pkg::ST_HEART : csta_pkg::ST_SCAN1;
				end
			end
			csta_pkg::ST_SCAN1: begin
				if (hit) begin
					state_d = csta_pkg::ST_DONE;
				end else if (pass_end) begin
					state_d = csta_pkg::ST_SCAN2;
				end
			end
			csta_pkg::ST_SCAN2: begin
				if (stop) begin
					state_d = csta_pkg::ST_DONE;
				end
			end
			csta_pkg::ST_HEART: begin
				state_d = csta_pkg::ST_DONE;
			end
			csta_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = csta_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csta_pkg::ST_CLEAR;
			end
		endcase
	end

	// Memory writes: the clearing pass, a granted slot, or a keepalive refresh.
	// A scan writes only at the slot where it stops and issues no read then, so a
	// read in flight cannot meet a write to the same slot.
	always_comb begin
		req.ready = 1'b0;
		mem_we    = '0;
		wr_addr   = clr_idx_q[IDX_W-1:0];
		wr_ip     = '0;
		wr_port   = '0;
		wr_seen   = '0;
		unique case (state_q) inside
			csta_pkg::ST_CLEAR: begin
				mem_we = '{id: 1'b1, seen: 1'b1};
			end
			csta_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			csta_pkg::ST_SCAN1, csta_pkg::ST_SCAN2: begin
				mem_we  = '{id: hit, seen: hit};
				wr_addr = idx_s1[IDX_W-1:0];
				wr_ip   = ip_q;
				wr_port = port_q;
				wr_seen = now_q;
			end
			csta_pkg::ST_HEART: begin
				mem_we  = '{id: 1'b0, seen: hb_ok};
				wr_addr = sel_m1[IDX_W-1:0];
				wr_seen = now_q;
			end
			csta_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csta_pkg::ST_CLEAR;
			clr_idx_q   <= '0;
			rd_idx_q    <= '0;
			rd_v_s1     <= 1'b0;
			out_v_q     <= 1'b0;
			base_port_q <= csta_pkg::BASE_PORT_RST;
			timeout_q   <= csta_pkg::TIMEOUT_RST;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (state_q == csta_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + CNT_W'(1);
			end
			if (accept || (hit1 == 1'b0 && pass_end && state_q == csta_pkg::ST_SCAN1)) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (state_q == csta_pkg::ST_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (csta_pkg::cfg_reg_t'(cfg_idx))
					csta_pkg::REG_BASE_PORT: base_port_q <= cfg_data[csta_pkg::PORT_W-1:0];
					csta_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data[csta_pkg::TIME_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ip_q   <= req.source_ip;
			port_q <= req.source_port;
			sel_q  <= req.slot_in;
			now_q  <= req.now_ms;
		end
		if (issue) begin
			idx_s1 <= rd_idx_q;
		end
		if (state_q == csta_pkg::ST_HEART) begin
			res_slot_q <= hb_ok ? SW'(sel_q) : '0;
			res_outc_q <= hb_ok ? csta_pkg::OUT_HEARTBEAT : csta_pkg::OUT_FULL;
		end else if (hit1) begin
			res_slot_q <= scan_slot;
			res_outc_q <= (rd_port == '0) ? csta_pkg::OUT_INSERTED : csta_pkg::OUT_MATCHED;
		end else if (hit2) begin
			res_slot_q <= scan_slot;
			res_outc_q <= csta_pkg::OUT_REPLACED;
		end else if (pass_end && state_q == csta_pkg::ST_SCAN2) begin
			res_slot_q <= '0;
			res_outc_q <= csta_pkg::OUT_FULL;
		end
		// The slot field carries the low bits of the slot number; the port wraps at
		// 16 bits, and a refused request reports port zero.
		if (state_q == csta_pkg::ST_DONE && out_free) begin
			out_slot_q <= res_slot_q[csta_pkg::SLOT_W-1:0];
			out_port_q <= (res_slot_q == '0) ? '0 :
				base_port_q + csta_pkg::PORT_W'(res_slot_q);
			out_outc_q <= res_outc_q;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.slot_index    = out_slot_q;
	assign rsp.assigned_port = out_port_q;
	assign rsp.outcome       = out_outc_q;

endmodule

// ===== rtl/csta_checker.sv =====
// Port-level checks of the session table response channel.
`include "client_session_table_aging_top_defines.svh"

module csta_checker #(
	parameter int SLOTS = 63
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [csta_pkg::SLOT_W-1:0]    rsp_slot_index,
	input logic [csta_pkg::PORT_W-1:0]    rsp_assigned_port,
	input logic [csta_pkg::OUTC_W-1:0]    rsp_outcome
);

	`CSTA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_outcome) && $stable(rsp_slot_index) && $stable(rsp_assigned_port), "response changed while stalled")
	`CSTA_ASSERT_NOW(a_outcome_code, rsp_valid, rsp_outcome <= csta_pkg::OUT_HEARTBEAT, "undefined outcome code")
	`CSTA_ASSERT_NOW(a_full_zero, rsp_valid && (rsp_outcome == csta_pkg::OUT_FULL), (rsp_slot_index == '0) && (rsp_assigned_port == '0), "refusal carries a slot or port")
	`CSTA_ASSERT_NOW(a_grant_slot, (SLOTS < 64) && rsp_valid && (rsp_outcome != csta_pkg::OUT_FULL), rsp_slot_index != '0, "granted slot is zero")

endmodule

bind client_session_table_aging_top csta_checker #(
	.SLOTS(SLOTS)
) u_csta_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_slot_index    (rsp.slot_index),
	.rsp_assigned_port (rsp.assigned_port),
	.rsp_outcome       (rsp.outcome)
);
